### hw/rtl/phase_sweep_peak_search_core_defines.svh
// Assertion macros used by the checker in psps_checker.sv.
`ifndef PHASE_SWEEP_PEAK_SEARCH_CORE_DEFINES_SVH
`define PHASE_SWEEP_PEAK_SEARCH_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PSPS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("psps assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define PSPS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("psps assertion failed");

`endif

### hw/rtl/psps_pkg.sv
`timescale 1ns / 1ps

package psps_pkg;

    localparam int MAX_IMAGES_DEF = 256;
    localparam int MAX_PIXELS_DEF = 65536;
    localparam int COUNT_LIMIT    = 131071;

    localparam int SAMPLE_W = 16;
    localparam int MEAN_W   = 16;
    localparam int PHASE_W  = 16;
    localparam int IDX_W    = 8;

    localparam logic signed [SAMPLE_W-1:0] INVALID_DB = -16'sd25344;
    localparam int PI_Q13     = 25736;
    localparam int TWO_PI_Q13 = 51472;

    localparam int DIV_STEPS = MEAN_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

    typedef enum logic [2:0] {
        ST_ACCEPT,
        ST_MUL,
        ST_CMP,
        ST_DIV,
        ST_LOAD
    } state_t;

    typedef struct packed {
        logic accumulate;
        logic close_image;
        logic multiply;
        logic compare;
        logic div_step;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic div_last;
        logic out_free;
    } status_t;

endpackage

### hw/rtl/psps_ctrl.sv
`timescale 1ns / 1ps

module psps_ctrl
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             pixel_valid,
    input  logic             last_of_image,
    output logic             pixel_stall,
    output psps_pkg::cmd_t   cmd,
    input  psps_pkg::status_t status
);

    psps_pkg::state_t state_reg;
    psps_pkg::state_t state_next;
    logic             accept;

    assign accept = pixel_valid && (state_reg == psps_pkg::ST_ACCEPT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= psps_pkg::ST_ACCEPT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            psps_pkg::ST_ACCEPT:
            begin
                if (accept && last_of_image)
                begin
                    state_next = psps_pkg::ST_MUL;
                end
            end
            psps_pkg::ST_MUL:
            begin
                state_next = psps_pkg::ST_CMP;
            end
            psps_pkg::ST_CMP:
            begin
                state_next = psps_pkg::ST_DIV;
            end
            psps_pkg::ST_DIV:
            begin
                if (status.div_last)
                begin
                    state_next = psps_pkg::ST_LOAD;
                end
            end
            psps_pkg::ST_LOAD:
            begin
                if (status.out_free)
                begin
                    state_next = psps_pkg::ST_ACCEPT;
                end
            end
            default:
            begin
                state_next = psps_pkg::ST_ACCEPT;
            end
        endcase
    end

    always_comb
    begin
        cmd         = '0;
        pixel_stall = 1'b1;
        case (state_reg)
            psps_pkg::ST_ACCEPT:
            begin
                pixel_stall      = 1'b0;
                cmd.accumulate   = accept;
                cmd.close_image  = accept && last_of_image;
            end
            psps_pkg::ST_MUL:
            begin
                cmd.multiply = 1'b1;
            end
            psps_pkg::ST_CMP:
            begin
                cmd.compare = 1'b1;
            end
            psps_pkg::ST_DIV:
            begin
                cmd.div_step = 1'b1;
            end
            psps_pkg::ST_LOAD:
            begin
                cmd.load_out = status.out_free;
            end
            default:
            begin
                pixel_stall = 1'b1;
            end
        endcase
    end

endmodule

### hw/rtl/psps_dpath.sv
`timescale 1ns / 1ps

module psps_dpath
#(
    parameter int MAX_IMAGES = psps_pkg::MAX_IMAGES_DEF,
    parameter int MAX_PIXELS = psps_pkg::MAX_PIXELS_DEF
)
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  psps_pkg::cmd_t                         cmd,
    output psps_pkg::status_t                      status,
    input  logic signed [psps_pkg::SAMPLE_W-1:0]   sample,
    input  logic        [psps_pkg::PHASE_W-1:0]    trial_phase,
    input  logic                                   last_of_sweep,
    input  logic                                   result_stall,
    output logic                                   result_valid,
    output logic        [psps_pkg::IDX_W-1:0]      image_index,
    output logic signed [psps_pkg::MEAN_W-1:0]     mean_power,
    output logic                                   image_empty,
    output logic                                   sweep_done,
    output logic        [psps_pkg::IDX_W-1:0]      best_index,
    output logic signed [psps_pkg::PHASE_W-1:0]    best_phase,
    output logic                                   index_saturated
);

    localparam int COUNT_CAP = (MAX_PIXELS < psps_pkg::COUNT_LIMIT) ?
                               MAX_PIXELS : psps_pkg::COUNT_LIMIT;
    localparam int CNT_W     = $clog2(COUNT_CAP + 1);
    localparam int SUM_W     = psps_pkg::SAMPLE_W + CNT_W;
    localparam int PROD_W    = SUM_W + CNT_W + 1;
    localparam int IMG_W     = $clog2(MAX_IMAGES + 1);
    localparam int MEAN_W    = psps_pkg::MEAN_W;
    localparam int IDX_W     = psps_pkg::IDX_W;
    localparam int PHASE_W   = psps_pkg::PHASE_W;
    localparam int DCW       = psps_pkg::DIV_CNT_W;

    // Running accumulation of the open image.
    logic signed [SUM_W-1:0]   sum_reg;
    logic        [CNT_W-1:0]   count_reg;
    logic signed [SUM_W-1:0]   sum_next;
    logic        [CNT_W-1:0]   count_next;
    logic                      pixel_ok;

    logic        [IMG_W-1:0]   img_cnt_reg;
    logic                      img_sat;
    logic        [IMG_W-1:0]   img_idx;

    // Snapshot of the image being closed.
    logic signed [SUM_W-1:0]   close_sum_reg;
    logic        [CNT_W-1:0]   close_count_reg;
    logic        [PHASE_W-1:0] close_phase_reg;
    logic        [IDX_W-1:0]   close_idx_reg;
    logic                      close_sat_reg;
    logic                      close_done_reg;
    logic                      close_empty;

    logic signed [PROD_W-1:0]  prod_new_reg;
    logic signed [PROD_W-1:0]  prod_best_reg;

    // Best image state.
    logic signed [SUM_W-1:0]   best_sum_reg;
    logic        [CNT_W-1:0]   best_count_reg;
    logic        [PHASE_W-1:0] best_phase_reg;
    logic        [IDX_W-1:0]   best_idx_reg;
    logic                      have_best_reg;
    logic                      take_new;

    // Shift and subtract divider on the magnitude of the sum.
    logic        [SUM_W-1:0]   sum_mag;
    logic        [CNT_W-1:0]   rem_reg;
    logic        [MEAN_W-1:0]  dq_reg;
    logic        [DCW-1:0]     div_cnt_reg;
    logic        [CNT_W:0]     rem_shift;
    logic                      rem_ge;
    logic        [CNT_W-1:0]   rem_next;
    logic        [MEAN_W-1:0]  mean_val;

    logic signed [PHASE_W:0]   phase_wrapped;

    logic                      result_valid_reg;

    assign pixel_ok   = (sample != psps_pkg::INVALID_DB) &&
                        (count_reg < CNT_W'(COUNT_CAP));
    assign sum_next   = pixel_ok ? (sum_reg + SUM_W'(sample)) : sum_reg;
    assign count_next = pixel_ok ? (count_reg + CNT_W'(1)) : count_reg;

    assign img_sat = (img_cnt_reg >= IMG_W'(MAX_IMAGES));
    assign img_idx = img_sat ? IMG_W'(MAX_IMAGES - 1) : img_cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg     <= '0;
            count_reg   <= '0;
            img_cnt_reg <= '0;
        end
        else
        begin
            if (cmd.close_image)
            begin
                sum_reg   <= '0;
                count_reg <= '0;
                if (!img_sat)
                begin
                    img_cnt_reg <= img_cnt_reg + IMG_W'(1);
                end
            end
            else if (cmd.accumulate)
            begin
                sum_reg   <= sum_next;
                count_reg <= count_next;
            end
            if (cmd.load_out && close_done_reg)
            begin
                img_cnt_reg <= '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.close_image)
        begin
            close_sum_reg   <= sum_next;
            close_count_reg <= count_next;
            close_phase_reg <= trial_phase;
            close_idx_reg   <= IDX_W'(img_idx);
            close_sat_reg   <= img_sat;
            close_done_reg  <= last_of_sweep;
        end
        if (cmd.multiply)
        begin
            prod_new_reg  <= PROD_W'(close_sum_reg) *
                             PROD_W'($signed({1'b0, best_count_reg}));
            prod_best_reg <= PROD_W'(best_sum_reg) *
                             PROD_W'($signed({1'b0, close_count_reg}));
        end
    end

    assign close_empty = (close_count_reg == '0);
    assign take_new    = !close_empty && (!have_best_reg || (prod_new_reg > prod_best_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_sum_reg   <= '0;
            best_count_reg <= '0;
            best_phase_reg <= '0;
            best_idx_reg   <= '0;
            have_best_reg  <= 1'b0;
        end
        else if (cmd.compare && take_new)
        begin
            best_sum_reg   <= close_sum_reg;
            best_count_reg <= close_count_reg;
            best_phase_reg <= close_phase_reg;
            best_idx_reg   <= close_idx_reg;
            have_best_reg  <= 1'b1;
        end
        else if (cmd.load_out && close_done_reg)
        begin
            best_sum_reg   <= '0;
            best_count_reg <= '0;
            best_phase_reg <= '0;
            best_idx_reg   <= '0;
            have_best_reg  <= 1'b0;
        end
    end

    // The mean fits in sixteen bits, so the upper sum bits start out below the count.
    assign sum_mag   = close_sum_reg[SUM_W-1] ? SUM_W'(-close_sum_reg) : SUM_W'(close_sum_reg);
    assign rem_shift = {rem_reg, dq_reg[MEAN_W-1]};
    assign rem_ge    = (rem_shift >= {1'b0, close_count_reg});
    assign rem_next  = rem_ge ? CNT_W'(rem_shift - {1'b0, close_count_reg})
                              : rem_shift[CNT_W-1:0];

    always_ff @(posedge clk)
    begin
        if (cmd.compare)
        begin
            rem_reg <= sum_mag[SUM_W-1:MEAN_W];
            dq_reg  <= sum_mag[MEAN_W-1:0];
        end
        else if (cmd.div_step)
        begin
            rem_reg <= rem_next;
            dq_reg  <= {dq_reg[MEAN_W-2:0], rem_ge};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_cnt_reg <= '0;
        end
        else if (cmd.compare)
        begin
            div_cnt_reg <= DCW'(psps_pkg::DIV_STEPS);
        end
        else if (cmd.div_step)
        begin
            div_cnt_reg <= div_cnt_reg - DCW'(1);
        end
    end

    assign mean_val = close_empty ? '0 :
                      (close_sum_reg[SUM_W-1] ? MEAN_W'(-dq_reg) : dq_reg);

    assign phase_wrapped = (best_phase_reg > PHASE_W'(psps_pkg::PI_Q13)) ?
                           ($signed({1'b0, best_phase_reg}) -
                            (PHASE_W+1)'(psps_pkg::TWO_PI_Q13)) :
                           $signed({1'b0, best_phase_reg});

    assign status.div_last = (div_cnt_reg == DCW'(1));
    assign status.out_free = !result_valid_reg || !result_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            image_index     <= close_idx_reg;
            mean_power      <= mean_val;
            image_empty     <= close_empty;
            sweep_done      <= close_done_reg;
            best_index      <= best_idx_reg;
            best_phase      <= phase_wrapped[PHASE_W-1:0];
            index_saturated <= close_sat_reg;
        end
    end

    assign result_valid = result_valid_reg;

endmodule

### hw/rtl/phase_sweep_peak_search_core.sv
// Pixels are taken one per cycle while an image is open.
// After the last pixel of an image the block stalls its input through one multiply,
// one compare and 16 steps of the shift and subtract divider, then the result word loads.
// The result word becomes valid once the divider has finished and holds until taken.
// Reset is asynchronous and active low; it clears the sums, counts and best image.
`timescale 1ns / 1ps

module phase_sweep_peak_search_core
#(
    parameter int MAX_IMAGES = psps_pkg::MAX_IMAGES_DEF,
    parameter int MAX_PIXELS = psps_pkg::MAX_PIXELS_DEF
)
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   pixel_valid,
    output logic                                   pixel_stall,
    input  logic signed [psps_pkg::SAMPLE_W-1:0]   sample,
    input  logic        [psps_pkg::PHASE_W-1:0]    trial_phase,
    input  logic                                   last_of_image,
    input  logic                                   last_of_sweep,
    output logic                                   result_valid,
    input  logic                                   result_stall,
    output logic        [psps_pkg::IDX_W-1:0]      image_index,
    output logic signed [psps_pkg::MEAN_W-1:0]     mean_power,
    output logic                                   image_empty,
    output logic                                   sweep_done,
    output logic        [psps_pkg::IDX_W-1:0]      best_index,
    output logic signed [psps_pkg::PHASE_W-1:0]    best_phase,
    output logic                                   index_saturated
);

    psps_pkg::cmd_t    cmd;
    psps_pkg::status_t status;

    psps_ctrl u_ctrl
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .pixel_valid   (pixel_valid),
        .last_of_image (last_of_image),
        .pixel_stall   (pixel_stall),
        .cmd           (cmd),
        .status        (status)
    );

    psps_dpath
    #(
        .MAX_IMAGES (MAX_IMAGES),
        .MAX_PIXELS (MAX_PIXELS)
    )
    u_dpath
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .sample          (sample),
        .trial_phase     (trial_phase),
        .last_of_sweep   (last_of_sweep),
        .result_stall    (result_stall),
        .result_valid    (result_valid),
        .image_index     (image_index),
        .mean_power      (mean_power),
        .image_empty     (image_empty),
        .sweep_done      (sweep_done),
        .best_index      (best_index),
        .best_phase      (best_phase),
        .index_saturated (index_saturated)
    );

endmodule

### hw/rtl/psps_checker.sv
`timescale 1ns / 1ps
`include "phase_sweep_peak_search_core_defines.svh"

module psps_checker
(
    input logic                                   clk,
    input logic                                   rst_n,
    input logic                                   pixel_valid,
    input logic                                   pixel_stall,
    input logic                                   last_of_image,
    input logic                                   result_valid,
    input logic                                   result_stall,
    input logic signed [psps_pkg::MEAN_W-1:0]     mean_power,
    input logic                                   image_empty,
    input logic signed [psps_pkg::PHASE_W-1:0]    best_phase
);

    `PSPS_ASSERT_NEXT(a_result_holds, clk, rst_n, result_valid && result_stall, result_valid)
    `PSPS_ASSERT_NEXT(a_close_stalls, clk, rst_n, pixel_valid && !pixel_stall && last_of_image, pixel_stall)
    `PSPS_ASSERT_IMP(a_empty_mean_zero, clk, rst_n, result_valid && image_empty, mean_power == '0)
    `PSPS_ASSERT_IMP(a_phase_in_range, clk, rst_n, result_valid, (int'(best_phase) <= psps_pkg::PI_Q13) && (int'(best_phase) > -psps_pkg::PI_Q13))

endmodule

bind phase_sweep_peak_search_core psps_checker u_psps_checker (.*);

### sim/phase_sweep_peak_search_core_checker.sv
`timescale 1ns / 1ps

module phase_sweep_peak_search_core_checker
#(
    parameter int MAX_IMAGES = psps_pkg::MAX_IMAGES_DEF,
    parameter int MAX_PIXELS = psps_pkg::MAX_PIXELS_DEF
)
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   pixel_valid,
    input  logic                                   pixel_stall,
    input  logic signed [psps_pkg::SAMPLE_W-1:0]   sample,
    input  logic        [psps_pkg::PHASE_W-1:0]    trial_phase,
    input  logic                                   last_of_image,
    input  logic                                   last_of_sweep,
    input  logic                                   result_valid,
    input  logic                                   result_stall,
    input  logic        [psps_pkg::IDX_W-1:0]      image_index,
    input  logic signed [psps_pkg::MEAN_W-1:0]     mean_power,
    input  logic                                   image_empty,
    input  logic                                   sweep_done,
    input  logic        [psps_pkg::IDX_W-1:0]      best_index,
    input  logic signed [psps_pkg::PHASE_W-1:0]    best_phase,
    input  logic                                   index_saturated,
    output int                                     mismatches,
    output int                                     results_outstanding,
    output int                                     results_checked
);

    localparam int PIXEL_CAP = (MAX_PIXELS < psps_pkg::COUNT_LIMIT) ?
                               MAX_PIXELS : psps_pkg::COUNT_LIMIT;
    localparam int REPORT_LIMIT = 40;

    typedef struct {
        logic        [psps_pkg::IDX_W-1:0]    image_index;
        logic signed [psps_pkg::MEAN_W-1:0]   mean_power;
        logic                                 image_empty;
        logic                                 sweep_done;
        logic        [psps_pkg::IDX_W-1:0]    best_index;
        logic signed [psps_pkg::PHASE_W-1:0]  best_phase;
        logic                                 index_saturated;
    } image_report_t;

    image_report_t report_queue[$];

    longint                         run_sum;
    int                             run_count;
    int                             images_seen;
    longint                         peak_sum;
    int                             peak_count;
    logic [psps_pkg::PHASE_W-1:0]   peak_phase;
    logic [psps_pkg::IDX_W-1:0]     peak_index;
    bit                             peak_held;

    task automatic clear_sweep;
        images_seen = 0;
        peak_sum    = 0;
        peak_count  = 0;
        peak_phase  = '0;
        peak_index  = '0;
        peak_held   = 1'b0;
    endtask

    task automatic fold_pixel(input logic signed [psps_pkg::SAMPLE_W-1:0] s,
                              input logic [psps_pkg::PHASE_W-1:0] ph,
                              input logic closes_image,
                              input logic closes_sweep);
        image_report_t rep;
        longint        mean_full;
        int            wrapped;
        int            slot;
        bit            saturated;
        if (s != psps_pkg::INVALID_DB && run_count < PIXEL_CAP)
        begin
            run_sum += s;
            run_count++;
        end
        if (closes_image)
        begin
            saturated = images_seen >= MAX_IMAGES;
            slot = saturated ? MAX_IMAGES - 1 : images_seen;
            if (!saturated)
                images_seen++;
            mean_full = 0;
            if (run_count != 0)
            begin
                mean_full = run_sum / longint'(run_count);
                if (!peak_held ||
                    run_sum * longint'(peak_count) > peak_sum * longint'(run_count))
                begin
                    peak_held  = 1'b1;
                    peak_sum   = run_sum;
                    peak_count = run_count;
                    peak_phase = ph;
                    peak_index = slot[psps_pkg::IDX_W-1:0];
                end
            end
            wrapped = 0;
            if (peak_held)
                wrapped = (peak_phase <= psps_pkg::PI_Q13) ?
                          int'(peak_phase) : int'(peak_phase) - psps_pkg::TWO_PI_Q13;
            rep.image_index     = slot[psps_pkg::IDX_W-1:0];
            rep.mean_power      = mean_full[psps_pkg::MEAN_W-1:0];
            rep.image_empty     = (run_count == 0);
            rep.sweep_done      = closes_sweep;
            rep.best_index      = peak_held ? peak_index : '0;
            rep.best_phase      = wrapped[psps_pkg::PHASE_W-1:0];
            rep.index_saturated = saturated;
            report_queue.push_back(rep);
            run_sum   = 0;
            run_count = 0;
            if (closes_sweep)
                clear_sweep();
        end
    endtask

    task automatic compare_field(input string field, input logic [15:0] want,
                                 input logic [15:0] got);
        if (got !== want)
        begin
            if (mismatches < REPORT_LIMIT)
                $display("%0t ns: %s mismatch, expected 0x%04h, actual 0x%04h",
                         $time, field, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        image_report_t exp_rep;
        if (!rst_n)
        begin
            report_queue.delete();
            run_sum   = 0;
            run_count = 0;
            clear_sweep();
            mismatches          = 0;
            results_outstanding = 0;
            results_checked     = 0;
        end
        else
        begin
            if (result_valid && !result_stall)
            begin
                if (report_queue.size() == 0)
                begin
                    if (mismatches < REPORT_LIMIT)
                        $display("%0t ns: result word with none expected, image_index 0x%02h",
                                 $time, image_index);
                    mismatches++;
                end
                else
                begin
                    exp_rep = report_queue.pop_front();
                    compare_field("image_index", exp_rep.image_index, image_index);
                    compare_field("mean_power", exp_rep.mean_power, mean_power);
                    compare_field("image_empty", exp_rep.image_empty, image_empty);
                    compare_field("sweep_done", exp_rep.sweep_done, sweep_done);
                    compare_field("best_index", exp_rep.best_index, best_index);
                    compare_field("best_phase", exp_rep.best_phase, best_phase);
                    compare_field("index_saturated", exp_rep.index_saturated,
                                  index_saturated);
                    results_checked++;
                end
            end
            if (pixel_valid && !pixel_stall)
                fold_pixel(sample, trial_phase, last_of_image, last_of_sweep);
            results_outstanding = report_queue.size();
        end
    end

endmodule

### sim/phase_sweep_peak_search_core_tb.sv
`timescale 1ns / 1ps

module phase_sweep_peak_search_core_tb;

    localparam int RANDOM_WORDS   = 1850;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int TAIL_CYCLES    = 40;

    localparam logic signed [15:0] SAMPLE_MAX = 16'sh7FFF;
    localparam logic signed [15:0] SAMPLE_MIN = 16'sh8000;
    localparam logic signed [15:0] NO_PIXEL   = psps_pkg::INVALID_DB;

    typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;
    typedef enum int {IMG_EMPTY, IMG_FLAT, IMG_MIXED} image_kind_t;

    logic                                   clk = 1'b0;
    logic                                   rst_n = 1'b0;
    logic                                   pixel_valid = 1'b0;
    logic                                   pixel_stall;
    logic signed [psps_pkg::SAMPLE_W-1:0]   sample = '0;
    logic        [psps_pkg::PHASE_W-1:0]    trial_phase = '0;
    logic                                   last_of_image = 1'b0;
    logic                                   last_of_sweep = 1'b0;
    logic                                   result_valid;
    logic                                   result_stall = 1'b0;
    logic        [psps_pkg::IDX_W-1:0]      image_index;
    logic signed [psps_pkg::MEAN_W-1:0]     mean_power;
    logic                                   image_empty;
    logic                                   sweep_done;
    logic        [psps_pkg::IDX_W-1:0]      best_index;
    logic signed [psps_pkg::PHASE_W-1:0]    best_phase;
    logic                                   index_saturated;

    int mismatch_count;
    int results_outstanding;
    int results_checked;

    int  words_sent = 0;
    int  images_sent = 0;
    int  sweeps_sent = 0;
    int  burst_left = 0;
    bit  steady = 1'b0;
    int  hold_asks = 0;
    int  holds_done = 0;
    int  stuck_cycles = 0;

    phase_sweep_peak_search_core dut (.*);

    phase_sweep_peak_search_core_checker checker_i (
        .*,
        .mismatches          (mismatch_count),
        .results_outstanding (results_outstanding),
        .results_checked     (results_checked)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    task automatic send_pixel(input logic signed [15:0] s, input logic [15:0] ph,
                              input logic closes_image, input logic closes_sweep);
        int gap;
        if (!steady)
        begin
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 40);
                gap = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30)
                                                  : $urandom_range(0, 4);
                if (gap != 0)
                begin
                    pixel_valid <= 1'b0;
                    repeat (gap) @(negedge clk);
                end
            end
            burst_left--;
        end
        sample        <= s;
        trial_phase   <= ph;
        last_of_image <= closes_image;
        last_of_sweep <= closes_sweep;
        pixel_valid   <= 1'b1;
        @(posedge clk);
        while (pixel_stall)
            @(posedge clk);
        @(negedge clk);
        words_sent++;
        if (closes_image)
        begin
            images_sent++;
            if (closes_sweep)
                sweeps_sent++;
        end
    endtask

    task automatic wait_for_results;
        pixel_valid <= 1'b0;
        @(negedge clk);
        while (results_outstanding != 0)
            @(negedge clk);
    endtask

    task automatic send_random_image(input bit closes_sweep);
        int                 npix;
        image_kind_t        kind;
        int                 pick;
        logic [15:0]        ph;
        logic [15:0]        pixel_ph;
        logic signed [15:0] level;
        logic signed [15:0] s;
        bit                 last;
        npix = ($urandom_range(0, 9) == 0) ? $urandom_range(12, 40) : $urandom_range(1, 6);
        pick = $urandom_range(0, 9);
        kind = (pick == 0) ? IMG_EMPTY : (pick <= 3) ? IMG_FLAT : IMG_MIXED;
        ph = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(psps_pkg::TWO_PI_Q13 + 1, 65535))
                                         : 16'($urandom_range(0, psps_pkg::TWO_PI_Q13));
        case ($urandom_range(0, 3))
            0: level = -16'sd512;
            1: level = 16'sd0;
            2: level = 16'sd256;
            default: level = 16'sd1280;
        endcase
        for (int k = 0; k < npix; k++)
        begin
            last = (k == npix - 1);
            case (kind)
                IMG_EMPTY: s = NO_PIXEL;
                IMG_FLAT:  s = level;
                default:
                begin
                    case ($urandom_range(0, 9))
                        0: s = NO_PIXEL;
                        1: s = SAMPLE_MAX;
                        2: s = SAMPLE_MIN;
                        default: s = 16'($urandom);
                    endcase
                end
            endcase
            pixel_ph = (!last && $urandom_range(0, 19) == 0) ? 16'($urandom) : ph;
            send_pixel(s, pixel_ph, last, last ? closes_sweep : ($urandom_range(0, 19) == 0));
        end
    endtask

    initial
    begin
        stall_mode_t mode;
        int          mode_left;
        int          hold_len;
        int          tick;
        mode = STALL_NONE;
        mode_left = 0;
        tick = 0;
        forever
        begin
            @(negedge clk);
            if (holds_done != hold_asks)
            begin
                holds_done = hold_asks;
                hold_len = $urandom_range(150, 300);
                result_stall <= 1'b1;
                repeat (hold_len) @(negedge clk);
            end
            if (mode_left == 0)
            begin
                mode = stall_mode_t'($urandom_range(0, 3));
                mode_left = $urandom_range(16, 160);
            end
            mode_left--;
            tick++;
            case (mode)
                STALL_NONE:  result_stall <= 1'b0;
                STALL_LIGHT: result_stall <= ($urandom_range(0, 3) == 0);
                STALL_HEAVY: result_stall <= ($urandom_range(0, 3) != 0);
                default:     result_stall <= ((tick % 7) < 3);
            endcase
        end
    end

    initial
    begin
        while (stuck_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if (rst_n && !((pixel_valid && !pixel_stall) || (result_valid && !result_stall)))
                stuck_cycles++;
            else
                stuck_cycles = 0;
        end
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        int n_images;
        int sweep_no;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Extremes, empty image, tie, lone sweep flag, truncation and phase wrap.
        send_pixel(SAMPLE_MAX, 16'd25736, 1'b1, 1'b0);
        send_pixel(NO_PIXEL, 16'd12345, 1'b0, 1'b0);
        send_pixel(NO_PIXEL, 16'd12345, 1'b1, 1'b0);
        send_pixel(SAMPLE_MIN, 16'd25737, 1'b0, 1'b0);
        send_pixel(16'sd0, 16'd25737, 1'b1, 1'b0);
        send_pixel(SAMPLE_MAX, 16'd65535, 1'b0, 1'b0);
        send_pixel(SAMPLE_MAX, 16'd65535, 1'b1, 1'b0);
        send_pixel(16'sd100, 16'd30000, 1'b0, 1'b1);
        send_pixel(-16'sd25343, 16'd30000, 1'b1, 1'b0);
        send_pixel(16'sd1, 16'd51472, 1'b0, 1'b0);
        send_pixel(16'sd2, 16'd51472, 1'b1, 1'b1);
        send_pixel(NO_PIXEL, 16'd40000, 1'b1, 1'b0);
        send_pixel(-16'sd3, 16'd65535, 1'b0, 1'b0);
        send_pixel(-16'sd4, 16'd65535, 1'b1, 1'b0);
        send_pixel(-16'sd1, 16'd0, 1'b0, 1'b0);
        send_pixel(-16'sd1, 16'd0, 1'b0, 1'b0);
        send_pixel(-16'sd1, 16'd0, 1'b1, 1'b0);
        send_pixel(16'sh5555, 16'hAAAA, 1'b0, 1'b0);
        send_pixel(16'shAAAA, 16'h5555, 1'b1, 1'b0);
        send_pixel(-16'sd1, 16'd51472, 1'b1, 1'b1);
        wait_for_results();

        sweep_no = 0;
        while (words_sent < RANDOM_WORDS)
        begin
            n_images = (sweep_no == 2) ? $urandom_range(258, 280) : $urandom_range(1, 12);
            // The receiver holds off while pixels keep coming, so the block backs up.
            if (sweep_no == 1 || $urandom_range(0, 15) == 0)
                hold_asks++;
            for (int i = 0; i < n_images; i++)
                send_random_image(i == n_images - 1);
            if ($urandom_range(0, 3) == 0)
                wait_for_results();
            steady = ($urandom_range(0, 4) == 0);
            sweep_no++;
        end
        wait_for_results();

        repeat (TAIL_CYCLES) @(negedge clk);
        $display("Sent %0d pixel words in %0d images over %0d sweeps; %0d results checked.",
                 words_sent, images_sent, sweeps_sent, results_checked);
        $display("Covered empty images, ties, phase wrap and index saturation under long stalls.");
        if (mismatch_count == 0 && results_outstanding == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

### phase_sweep_peak_search_core.f
+incdir+hw/rtl
hw/rtl/psps_pkg.sv
hw/rtl/psps_ctrl.sv
hw/rtl/psps_dpath.sv
hw/rtl/phase_sweep_peak_search_core.sv
hw/rtl/psps_checker.sv
sim/phase_sweep_peak_search_core_checker.sv
sim/phase_sweep_peak_search_core_tb.sv
